>>> hw/rtl/mtd_pkg.sv
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types and constants for the morse timing decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int DOT_BITS  = 5;
  localparam int INDEX_BITS = 7;
  localparam int CHAR_BITS = 7;

  localparam logic [DOT_BITS-1:0]   DOT_LENGTH_RESET = 5'd4;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX        = 7'd127;
  localparam logic [CHAR_BITS-1:0]  SPACE_CHAR       = 7'h20;

  // code tree table, index 63 holds nul
  localparam logic [CHAR_BITS-1:0] CODE_TABLE [64] = '{
    7'h20, 7'h45, 7'h54, 7'h49, 7'h41, 7'h4E, 7'h4D, 7'h53,
    7'h55, 7'h52, 7'h57, 7'h44, 7'h4B, 7'h47, 7'h4F, 7'h48,
    7'h56, 7'h46, 7'h20, 7'h4C, 7'h40, 7'h50, 7'h4A, 7'h42,
    7'h58, 7'h43, 7'h59, 7'h5A, 7'h51, 7'h2D, 7'h2A, 7'h35,
    7'h34, 7'h2E, 7'h33, 7'h2C, 7'h3A, 7'h7C, 7'h32, 7'h21,
    7'h3F, 7'h2B, 7'h23, 7'h24, 7'h26, 7'h27, 7'h31, 7'h36,
    7'h3D, 7'h2F, 7'h28, 7'h29, 7'h3C, 7'h3E, 7'h5B, 7'h37,
    7'h5D, 7'h7B, 7'h7D, 7'h38, 7'h5F, 7'h39, 7'h30, 7'h00
  };

  typedef struct packed {
    logic valid;
    logic level;
  } stage_t;

endpackage

>>> hw/rtl/mtd_if.sv
// ----------------------------------------------------------------------------
// mtd_if
// Handshake channels for light samples and decoded characters.
// ----------------------------------------------------------------------------
interface mtd_level_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface mtd_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

>>> hw/rtl/mtd_in_stage.sv
// ----------------------------------------------------------------------------
// mtd_in_stage
// Input register for one light sample beat.
// ----------------------------------------------------------------------------
module mtd_in_stage
  import mtd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   in_level,
  output logic   in_ready,
  input  logic   take,
  output stage_t stage
);

  assign in_ready = !stage.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_ready) begin
      stage.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage.level <= in_level;
    end
  end

endmodule

>>> hw/rtl/mtd_fsm.sv
// ----------------------------------------------------------------------------
// mtd_fsm
// Pulse timing state machine, code tree index and result register.
// ----------------------------------------------------------------------------
module mtd_fsm
  import mtd_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [DOT_BITS-1:0]  cfg_data,
  input  stage_t               stage,
  output logic                 take,
  output logic                 out_valid,
  output logic [CHAR_BITS-1:0] out_char,
  input  logic                 out_ready
);

  typedef enum logic [2:0] {
    IDLE,
    DOT,
    DASH,
    INTERSYMBOL,
    INTERCHAR
  } phase_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, count_mid, tick_count_next;
  logic [INDEX_BITS-1:0] code_index, code_index_next;
  logic [DOT_BITS-1:0]   dot_length;
  logic [COUNT_BITS-1:0] limit;
  logic                  over;
  logic                  emit;
  logic [CHAR_BITS-1:0]  char_next;
  logic [INDEX_BITS+1:0] grown;
  logic [1:0]            grow_add;

  assign take  = stage.valid && (!out_valid || out_ready);
  assign limit = COUNT_BITS'({dot_length, 1'b0});
  assign over  = tick_count > limit;
  assign grown = {1'b0, code_index, 1'b0} + {{INDEX_BITS{1'b0}}, grow_add};

  always_comb begin
    phase_next      = phase;
    count_mid       = tick_count;
    code_index_next = code_index;
    grow_add        = 2'd1;
    emit            = 1'b0;
    unique case (phase)
      IDLE: begin
        count_mid = '0;
        if (stage.level) begin
          phase_next      = DOT;
          code_index_next = '0;
        end
      end
      DOT: begin
        if (!stage.level) begin
          grow_add        = 2'd1;
          code_index_next = (grown > {2'b00, INDEX_MAX}) ? INDEX_MAX : grown[INDEX_BITS-1:0];
          count_mid       = '0;
          phase_next      = INTERSYMBOL;
        end else if (over) begin
          phase_next = DASH;
        end
      end
      DASH: begin
        grow_add = 2'd2;
        if (!stage.level) begin
          code_index_next = (grown > {2'b00, INDEX_MAX}) ? INDEX_MAX : grown[INDEX_BITS-1:0];
          count_mid       = '0;
          phase_next      = INTERSYMBOL;
        end
      end
      INTERSYMBOL: begin
        if (!stage.level) begin
          if (over) begin
            phase_next = INTERCHAR;
          end
        end else begin
          count_mid  = '0;
          phase_next = DOT;
        end
      end
      INTERCHAR: begin
        if (!stage.level) begin
          if (over) begin
            emit       = 1'b1;
            phase_next = IDLE;
          end
        end else begin
          code_index_next = '0;
          count_mid       = '0;
          phase_next      = DOT;
        end
      end
      default: begin
        phase_next = IDLE;
        count_mid  = '0;
      end
    endcase
    tick_count_next = (count_mid < COUNT_MAX) ? count_mid + 1'b1 : count_mid;
    char_next = code_index[INDEX_BITS-1] ? SPACE_CHAR
                                         : CODE_TABLE[code_index[INDEX_BITS-2:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= IDLE;
      tick_count <= '0;
      code_index <= '0;
      dot_length <= DOT_LENGTH_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        dot_length <= cfg_data;
      end
      if (take) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        code_index <= code_index_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take && emit) begin
      out_char <= char_next;
    end
  end

endmodule

>>> hw/rtl/morse_timing_decoder.sv
// ----------------------------------------------------------------------------
// morse_timing_decoder
// Sorts sampled light pulses into dots and dashes and emits ASCII characters.
// Takes one level beat per clock cycle unless stalled; a beat moves from the
// input register through the timing state machine into the result register,
// where the character that the beat ends is captured. Throughput is set by
// the state update: one beat per cycle, held off only while an undelivered
// character blocks the result register. dot_length is written through
// cfg_we/cfg_data; the dash and gap threshold is twice it.
// ----------------------------------------------------------------------------
module morse_timing_decoder
  import mtd_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [DOT_BITS-1:0] cfg_data,
  mtd_level_if.sink           samples,
  mtd_char_if.source          chars
);

  stage_t stage;
  logic   take;

  mtd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_level (samples.level),
    .in_ready (samples.ready),
    .take     (take),
    .stage    (stage)
  );

  mtd_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .take      (take),
    .out_valid (chars.valid),
    .out_char  (chars.char_code),
    .out_ready (chars.ready)
  );

endmodule

>>> tb/sv/mtd_decode_check.sv
// ----------------------------------------------------------------------------
// mtd_decode_check
// Watches the sample and character channels of the morse timing decoder,
// keeps its own copy of the timing state and dot length, works out the
// character that each accepted sample beat yields and compares every
// delivered character with the oldest one still owed.
// ----------------------------------------------------------------------------
module mtd_decode_check
  import mtd_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [DOT_BITS-1:0] cfg_data,
  mtd_level_if                samples,
  mtd_char_if                 chars,
  output int                  errors,
  output int                  pending
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_DASH,
    ST_SYM_GAP,
    ST_CHAR_GAP
  } timing_state_e;

  localparam logic [1:0] MARK_DOT  = 2'd1;
  localparam logic [1:0] MARK_DASH = 2'd2;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  string morse_tree = " ETIANMSURWDKGOHVF L@PJBXCYZQ-*54.3,:|2!?+#$&'16=/()<>[7]{}8_90";

  timing_state_e         state;
  logic [COUNT_BITS-1:0] ticks;
  logic [INDEX_BITS-1:0] tree_idx;
  logic [DOT_BITS-1:0]   dot_len;
  logic [CHAR_BITS-1:0]  owed_chars [$];

  function automatic logic [INDEX_BITS-1:0] extend_index(input logic [INDEX_BITS-1:0] idx,
                                                         input logic [1:0] mark);
    logic [INDEX_BITS+1:0] grown;
    grown = {1'b0, idx, 1'b0} + {{INDEX_BITS{1'b0}}, mark};
    return (grown > {2'b00, INDEX_MAX}) ? INDEX_MAX : grown[INDEX_BITS-1:0];
  endfunction

  function automatic logic [CHAR_BITS-1:0] char_at(input logic [INDEX_BITS-1:0] idx);
    byte ch;
    // index 63 is past the end of the tree string and reads as nul
    if (idx >= 7'd64) return SPACE_CHAR;
    if (int'(idx) >= morse_tree.len()) return '0;
    ch = morse_tree[idx];
    return ch[CHAR_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [CHAR_BITS-1:0] got,
                                 input logic [CHAR_BITS-1:0] want);
    errors++;
    $display("[%0t] %s: got %02h expected %02h", $realtime, what, got, want);
  endtask

  task automatic advance_timing(input logic lv);
    logic [DOT_BITS:0] thr;
    thr = {dot_len, 1'b0};
    case (state)
      ST_IDLE: begin
        ticks = '0;
        if (lv) begin
          state = ST_DOT;
          tree_idx = '0;
        end
      end
      ST_DOT: begin
        if (!lv) begin
          tree_idx = extend_index(tree_idx, MARK_DOT);
          ticks = '0;
          state = ST_SYM_GAP;
        end else if (ticks > thr) begin
          state = ST_DASH;
        end
      end
      ST_DASH: begin
        if (!lv) begin
          tree_idx = extend_index(tree_idx, MARK_DASH);
          ticks = '0;
          state = ST_SYM_GAP;
        end
      end
      ST_SYM_GAP: begin
        if (!lv) begin
          if (ticks > thr) state = ST_CHAR_GAP;
        end else begin
          ticks = '0;
          state = ST_DOT;
        end
      end
      ST_CHAR_GAP: begin
        if (!lv) begin
          if (ticks > thr) begin
            owed_chars.push_back(char_at(tree_idx));
            state = ST_IDLE;
          end
        end else begin
          tree_idx = '0;
          ticks = '0;
          state = ST_DOT;
        end
      end
      default: begin
        state = ST_IDLE;
        ticks = '0;
      end
    endcase
    if (ticks != COUNT_TOP) ticks = ticks + 1'b1;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      state = ST_IDLE;
      ticks = '0;
      tree_idx = '0;
      dot_len = DOT_LENGTH_RESET;
      owed_chars.delete();
    end else begin
      if (cfg_we) dot_len = cfg_data;
      if (samples.valid && samples.ready) advance_timing(samples.level);
      if (chars.valid && chars.ready) begin
        if (owed_chars.size() == 0)
          report_mismatch("unexpected char_code", chars.char_code, '0);
        else if (chars.char_code !== owed_chars[0]) begin
          report_mismatch("char_code mismatch", chars.char_code, owed_chars[0]);
          void'(owed_chars.pop_front());
        end else begin
          void'(owed_chars.pop_front());
        end
      end
    end
    pending <= owed_chars.size();
  end

endmodule

>>> tb/sv/tb_morse_timing_decoder.sv
// ----------------------------------------------------------------------------
// tb_morse_timing_decoder
// Drives light samples into the morse timing decoder: a directed set of
// characters and corner cases, then random well-formed characters mixed with
// noise under several dot lengths and handshake idling patterns, including a
// long receiver hold-off. A separate check module predicts and compares.
// ----------------------------------------------------------------------------
module tb_morse_timing_decoder;
  import mtd_pkg::*;

  localparam int COUNT_BITS  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [DOT_BITS-1:0] cfg_data;
  logic                hold_go;
  logic                hold_rx;
  int                  send_gap_pct;
  int                  recv_stall_pct;
  int                  errors;
  int                  pending;
  int                  cycle_count;
  int                  ticks_sent;

  mtd_level_if samples ();
  mtd_char_if  chars ();

  morse_timing_decoder #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .samples (samples),
    .chars   (chars)
  );

  mtd_decode_check #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode_check (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .samples (samples),
    .chars   (chars),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver side
  initial begin
    chars.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst || hold_rx) begin
        chars.ready <= 1'b0;
      end else begin
        chars.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // long hold-off so the block backs up into its input
  initial begin
    hold_rx = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic send_level(input logic lv);
    while ($urandom_range(99) < send_gap_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.level <= lv;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_run(input logic lv, input int n);
    repeat (n) send_level(lv);
  endtask

  task automatic settle();
    samples.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dot_length(input logic [DOT_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one character of random marks at lengths around the thresholds
  task automatic send_char(input int dl);
    int thr;
    int marks;
    thr = 2 * dl;
    marks = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 8);
    for (int m = 0; m < marks; m++) begin
      if ($urandom_range(1))
        send_run(1'b1, $urandom_range(thr + 2, thr + 4 + dl));
      else
        send_run(1'b1, $urandom_range(1, thr + 1));
      if (m != marks - 1) send_run(1'b0, $urandom_range(1, thr + 1));
    end
    send_run(1'b0, $urandom_range(thr + 3, thr + 6));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12)) send_level(1'($urandom_range(1)));
  endtask

  task automatic random_phase(input logic [DOT_BITS-1:0] dl, input int gap_pct,
                              input int stall_pct, input int n_ticks);
    int target;
    settle();
    write_dot_length(dl);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    target = ticks_sent + n_ticks;
    while (ticks_sent < target) begin
      if ($urandom_range(99) < 85) send_char(dl);
      else send_noise();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    samples.valid = 1'b0;
    samples.level = 1'b0;
    hold_go = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    ticks_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset dot length: dot then dash
    send_run(1'b1, 2);
    send_run(1'b0, 3);
    send_run(1'b1, 12);
    send_run(1'b0, 12);
    settle();
    write_dot_length(5'd1);
    send_run(1'b1, 1);
    send_run(1'b0, 6);
    // six dots land on the nul entry
    repeat (6) begin
      send_run(1'b1, 1);
      send_run(1'b0, 2);
    end
    send_run(1'b0, 4);
    // six dashes give an index past the table
    repeat (6) begin
      send_run(1'b1, 4);
      send_run(1'b0, 2);
    end
    send_run(1'b0, 4);
    // eight marks saturate the index
    repeat (8) begin
      send_run(1'b1, $urandom_range(1, 4));
      send_run(1'b0, 1);
    end
    send_run(1'b0, 5);
    // tick count saturates on a very long mark
    send_run(1'b1, 300);
    send_run(1'b0, 6);
    // stop in the character gap, then raise the threshold
    send_run(1'b1, 1);
    send_run(1'b0, 4);
    settle();
    write_dot_length(5'd31);
    send_run(1'b0, 70);
    settle();
    // zero dot length: two ticks high already make a dash
    write_dot_length(5'd0);
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 3);

    random_phase(5'd2, 0, 0, 180);
    random_phase(5'd1, 46, 0, 180);
    random_phase(5'd3, 0, 46, 180);
    random_phase(5'd0, 32, 32, 180);

    settle();
    write_dot_length(5'd1);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_go <= 1'b1;
    repeat (12) send_char(1);

    random_phase(5'd31, 0, 20, 100);

    settle();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
